// File: hdl/smpt_pkg.sv
// Shared types and constants for the serial mouse packet tracker.
package smpt_pkg;

    // Width of a pointer coordinate and of the window registers.
    localparam int unsigned COORD_WIDTH = 12;
    // Pointer position after reset.
    localparam logic [COORD_WIDTH-1:0] RESET_POS = COORD_WIDTH'(200);
    // Window registers after reset.
    localparam logic [COORD_WIDTH-1:0] RESET_X_MAX = COORD_WIDTH'(639);
    localparam logic [COORD_WIDTH-1:0] RESET_Y_MAX = COORD_WIDTH'(479);

    // Operation carried by an input word.
    typedef enum logic [0:0] {
        OP_BYTE = 1'b0,
        OP_SET  = 1'b1
    } op_t;

    // Kind of an output event.
    typedef enum logic [2:0] {
        EV_MOVE          = 3'd0,
        EV_LEFT_PRESS    = 3'd1,
        EV_LEFT_RELEASE  = 3'd2,
        EV_RIGHT_PRESS   = 3'd3,
        EV_RIGHT_RELEASE = 3'd4
    } event_kind_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_X_MIN = 2'd0,
        REG_Y_MIN = 2'd1,
        REG_X_MAX = 2'd2,
        REG_Y_MAX = 2'd3
    } reg_index_t;

    // Position of the next byte within a frame.
    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_XLOW   = 3'b010,
        PH_YLOW   = 3'b100
    } phase_t;

    // Input word.
    typedef struct packed {
        logic [0:0]             op;
        logic [7:0]             rx_byte;
        logic [COORD_WIDTH-1:0] set_x;
        logic [COORD_WIDTH-1:0] set_y;
    } in_word_t;

    // Output word.
    typedef struct packed {
        logic [2:0]             event_kind;
        logic [COORD_WIDTH-1:0] pointer_x;
        logic [COORD_WIDTH-1:0] pointer_y;
        logic                   last;
    } out_word_t;

    // Pointer window.
    typedef struct packed {
        logic [COORD_WIDTH-1:0] x_min;
        logic [COORD_WIDTH-1:0] y_min;
        logic [COORD_WIDTH-1:0] x_max;
        logic [COORD_WIDTH-1:0] y_max;
    } window_t;

    // Tracker state kept between input words.
    typedef struct packed {
        phase_t                 phase;
        logic [7:0]             header;
        logic [7:0]             x_low;
        logic [COORD_WIDTH-1:0] pos_x;
        logic [COORD_WIDTH-1:0] pos_y;
        logic                   left_down;
        logic                   right_down;
    } track_state_t;

    // Events raised by one input word, in emission order move, left, right.
    typedef struct packed {
        logic                   move;
        logic                   left;
        logic                   left_press;
        logic                   right;
        logic                   right_press;
        logic [COORD_WIDTH-1:0] pos_x;
        logic [COORD_WIDTH-1:0] pos_y;
    } event_set_t;

endpackage

// File: hdl/smpt_step.sv
// Next-state and event logic for one input word of the packet tracker.
module smpt_step (
    input  smpt_pkg::in_word_t     in_word,
    input  smpt_pkg::track_state_t cur,
    input  smpt_pkg::window_t      win,
    output smpt_pkg::track_state_t nxt,
    output smpt_pkg::event_set_t   events
);

    localparam int unsigned SUM_W = smpt_pkg::COORD_WIDTH + 2;

    // Apply the minimum first and the maximum last, as an inverted window demands.
    function automatic logic [smpt_pkg::COORD_WIDTH-1:0] clamp_axis(
        input logic signed [SUM_W-1:0]         v,
        input logic [smpt_pkg::COORD_WIDTH-1:0] lo,
        input logic [smpt_pkg::COORD_WIDTH-1:0] hi
    );
        logic signed [SUM_W-1:0] r;
        r = v;
        if (r < $signed({2'b00, lo})) begin
            r = $signed({2'b00, lo});
        end
        if (r > $signed({2'b00, hi})) begin
            r = $signed({2'b00, hi});
        end
        return r[smpt_pkg::COORD_WIDTH-1:0];
    endfunction

    logic [7:0]              rx;
    smpt_pkg::phase_t        phase_eff;
    logic [7:0]              dx;
    logic [7:0]              dy;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic [smpt_pkg::COORD_WIDTH-1:0] new_x;
    logic [smpt_pkg::COORD_WIDTH-1:0] new_y;
    logic                    new_left;
    logic                    new_right;

    assign rx = in_word.rx_byte;

    // A byte with the sync bit always opens a new frame.
    assign phase_eff = rx[6] ? smpt_pkg::PH_HEADER : cur.phase;

    // Rebuild the signed deltas from the header and the two data bytes.
    assign dx = {cur.header[1:0], cur.x_low[5:0]};
    assign dy = {cur.header[3:2], rx[5:0]};

    assign sum_x = $signed({2'b00, cur.pos_x}) + $signed({{(SUM_W-8){dx[7]}}, dx});
    assign sum_y = $signed({2'b00, cur.pos_y}) + $signed({{(SUM_W-8){dy[7]}}, dy});

    assign new_x     = clamp_axis(sum_x, win.x_min, win.x_max);
    assign new_y     = clamp_axis(sum_y, win.y_min, win.y_max);
    assign new_left  = cur.header[5];
    assign new_right = cur.header[4];

    // Take the pointer from a set word, or advance the frame and collect the events of a completed packet.
    always_comb
    begin
        nxt    = cur;
        events = '0;
        events.pos_x = new_x;
        events.pos_y = new_y;
        if (in_word.op == smpt_pkg::OP_SET) begin
            nxt.pos_x = in_word.set_x;
            nxt.pos_y = in_word.set_y;
        end else begin
            case (phase_eff)
                smpt_pkg::PH_XLOW:
                begin
                    nxt.x_low = rx;
                    nxt.phase = smpt_pkg::PH_YLOW;
                end
                smpt_pkg::PH_YLOW:
                begin
                    nxt.phase      = smpt_pkg::PH_HEADER;
                    nxt.pos_x      = new_x;
                    nxt.pos_y      = new_y;
                    nxt.left_down  = new_left;
                    nxt.right_down = new_right;
                    events.move        = (new_x != cur.pos_x) || (new_y != cur.pos_y);
                    events.left        = new_left != cur.left_down;
                    events.left_press  = new_left;
                    events.right       = new_right != cur.right_down;
                    events.right_press = new_right;
                end
                default:
                begin
                    // Header position, also taken by a data byte at frame start.
                    nxt.header = rx;
                    nxt.phase  = smpt_pkg::PH_XLOW;
                end
            endcase
        end
    end

endmodule

// File: hdl/serial_mouse_packet_tracker.sv
// Top level of the serial mouse packet tracker: state, window and event queue.
// The first event of a packet is offered in the cycle after its last byte is accepted.
// Throughput: one input word per cycle while each word raises at most one event and the output
// is not stalled; a packet raising more events holds the input while the event register drains.
// Events leave one per cycle, limited only by the output stall.
// Reset: pointer at (200, 200), window x 0..639 and y 0..479, frame at header, buttons up.
module serial_mouse_packet_tracker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  smpt_pkg::in_word_t                in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output smpt_pkg::out_word_t               out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [smpt_pkg::COORD_WIDTH-1:0]  cfg_data
);

    smpt_pkg::track_state_t state_reg;
    smpt_pkg::track_state_t state_next;
    smpt_pkg::window_t      win_reg;
    smpt_pkg::event_set_t   pend_reg;
    smpt_pkg::event_set_t   pend_next;
    smpt_pkg::event_set_t   step_events;
    logic                   in_accept;
    logic                   out_accept;
    logic [1:0]             pend_count;

    // Per-word logic.
    smpt_step u_step (
        .in_word (in_data),
        .cur     (state_reg),
        .win     (win_reg),
        .nxt     (state_next),
        .events  (step_events)
    );

    // Handshakes: a new word is taken only if the event register is empty after this cycle.
    assign pend_count = 2'(pend_reg.move) + 2'(pend_reg.left) + 2'(pend_reg.right);
    assign out_valid  = pend_count != 2'd0;
    assign out_accept = out_valid && !out_stall;
    assign in_stall   = (pend_count > 2'd1) || (out_valid && out_stall);
    assign in_accept  = in_valid && !in_stall;
    assign cfg_ready  = 1'b1;

    // Present the earliest pending event.
    always_comb
    begin
        out_data.pointer_x = pend_reg.pos_x;
        out_data.pointer_y = pend_reg.pos_y;
        if (pend_reg.move) begin
            out_data.event_kind = smpt_pkg::EV_MOVE;
            out_data.last       = !(pend_reg.left || pend_reg.right);
        end else if (pend_reg.left) begin
            out_data.event_kind = pend_reg.left_press ? smpt_pkg::EV_LEFT_PRESS
                                                      : smpt_pkg::EV_LEFT_RELEASE;
            out_data.last       = !pend_reg.right;
        end else begin
            out_data.event_kind = pend_reg.right_press ? smpt_pkg::EV_RIGHT_PRESS
                                                       : smpt_pkg::EV_RIGHT_RELEASE;
            out_data.last       = 1'b1;
        end
    end

    // Drain the event register, or load it with the events of a new word.
    always_comb
    begin
        pend_next = pend_reg;
        if (out_accept) begin
            if (pend_reg.move) begin
                pend_next.move = 1'b0;
            end else if (pend_reg.left) begin
                pend_next.left = 1'b0;
            end else begin
                pend_next.right = 1'b0;
            end
        end
        if (in_accept) begin
            pend_next = step_events;
        end
    end

    // Tracker state and event register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg.phase      <= smpt_pkg::PH_HEADER;
            state_reg.header     <= '0;
            state_reg.x_low      <= '0;
            state_reg.pos_x      <= smpt_pkg::RESET_POS;
            state_reg.pos_y      <= smpt_pkg::RESET_POS;
            state_reg.left_down  <= 1'b0;
            state_reg.right_down <= 1'b0;
            pend_reg             <= '0;
        end else begin
            if (in_accept) begin
                state_reg <= state_next;
            end
            pend_reg <= pend_next;
        end
    end

    // Window registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            win_reg.x_min <= '0;
            win_reg.y_min <= '0;
            win_reg.x_max <= smpt_pkg::RESET_X_MAX;
            win_reg.y_max <= smpt_pkg::RESET_Y_MAX;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                smpt_pkg::REG_X_MIN: win_reg.x_min <= cfg_data;
                smpt_pkg::REG_Y_MIN: win_reg.y_min <= cfg_data;
                smpt_pkg::REG_X_MAX: win_reg.x_max <= cfg_data;
                smpt_pkg::REG_Y_MAX: win_reg.y_max <= cfg_data;
                default: win_reg <= win_reg;
            endcase
        end
    end

endmodule

// File: hdl/smpt_checker.sv
// Port-level checks for the packet tracker, bound to its top level.
module smpt_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input smpt_pkg::out_word_t               out_data
);

    // A stalled output word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output word changed");

    // While further events of a packet wait, no new input word is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last |-> in_stall)
        else $error("input taken while a packet still has events queued");

    // An event that is not the last of its packet is followed by another.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_data.last |=> out_valid)
        else $error("packet events ended without a last flag");

    // Event kinds stay within the defined set.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.event_kind <= smpt_pkg::EV_RIGHT_RELEASE)
        else $error("undefined event kind");

endmodule

bind serial_mouse_packet_tracker smpt_checker u_smpt_checker (.*);
